>>> hw/rtl/yuv_to_rgb_render_modes_macros.svh
// ----------------------------------------------------------------------------
// yuv_to_rgb_render_modes assertion macros
// Shared concurrent assertion forms for the pixel converter.
// ----------------------------------------------------------------------------
`ifndef YUV_TO_RGB_RENDER_MODES_MACROS_SVH
`define YUV_TO_RGB_RENDER_MODES_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define YRM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yuv_to_rgb_render_modes: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define YRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yuv_to_rgb_render_modes: next-cycle check failed");

`endif

>>> hw/rtl/yuv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Word types, mode codes and fixed-point constants of the YUV to RGB converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yuv2rgb_pkg;

   // Input word: one pixel
   typedef struct packed {
      logic [7:0] luma_sample;
      logic [7:0] blue_diff_sample;
      logic [7:0] red_diff_sample;
   } req_type;

   // Result word: three output bytes
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // Render mode codes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_GREY   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COLOUR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GREEN  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_GREY;

   // Fixed point: coefficients over 2^FRAC_BITS
   localparam int FRAC_BITS = 10;
   localparam int PROD_W    = 20;
   localparam int ACC_W     = PROD_W + 1;
   localparam int Q_W       = ACC_W - FRAC_BITS;

   localparam logic signed [PROD_W-1:0] COEF_Y  = 20'sd1192;
   localparam logic signed [PROD_W-1:0] COEF_RV = 20'sd1634;
   localparam logic signed [PROD_W-1:0] COEF_GU = 20'sd401;
   localparam logic signed [PROD_W-1:0] COEF_GV = 20'sd833;
   localparam logic signed [PROD_W-1:0] COEF_BU = 20'sd2065;

   localparam logic signed [8:0] LUMA_OFFSET = 9'sd16;

   // Divide by three: floor(s * 683 / 2048) is exact for s up to 765
   localparam int SUM_W       = 10;
   localparam int GREY_PROD_W = 2 * SUM_W;
   localparam int GREY_SHIFT  = 11;
   localparam logic [GREY_PROD_W-1:0] GREY_RECIP = 20'd683;

   // Floor shift of the accumulator, then clamp to 0..255
   function automatic logic [7:0] clamp_pixel(input logic signed [ACC_W-1:0] acc);
      logic signed [Q_W-1:0] q;
      q = acc[ACC_W-1:FRAC_BITS];
      if (q < 0) begin
         return 8'd0;
      end else if (q > 255) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/yuv_to_rgb_render_modes.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_render_modes
// BT.601 studio-range YUV to RGB pixel converter with grey, colour and
// green-luma render modes.
// ----------------------------------------------------------------------------
// One pixel is taken at every clock edge with start high and busy low; busy is
// high only during reset, so the converter takes one pixel per clock without
// pause. Each result appears on rsp_data once its pixel has passed the three
// register stages below, marked by rsp_strobe for one cycle; there is no
// hold-off, so the receiver must take every result as it comes. The stages
// are coefficient multiply, sum with floor shift and clamp, then grey average
// and mode select. The render mode register is sampled together with each
// pixel and travels with it down the pipeline.
`timescale 1ns / 1ps
`default_nettype none

`include "yuv_to_rgb_render_modes_macros.svh"

module yuv_to_rgb_render_modes (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input channel
   input  wire logic                         start,
   output logic                              busy,
   input  wire yuv2rgb_pkg::req_type         req_data,
   // result channel
   output logic                              rsp_strobe,
   output yuv2rgb_pkg::rsp_type              rsp_data,
   // configuration channel
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [yuv2rgb_pkg::MODE_W-1:0] csr_data
);
   import yuv2rgb_pkg::*;

   // Mode register
   logic [MODE_W-1:0] mode_ff;

   // Stage 1 signals
   logic signed [8:0]        luma_off;
   logic signed [7:0]        cb_off;
   logic signed [7:0]        cr_off;
   logic signed [PROD_W-1:0] s1_y_in,  s1_y_ff;
   logic signed [PROD_W-1:0] s1_rv_in, s1_rv_ff;
   logic signed [PROD_W-1:0] s1_gu_in, s1_gu_ff;
   logic signed [PROD_W-1:0] s1_gv_in, s1_gv_ff;
   logic signed [PROD_W-1:0] s1_bu_in, s1_bu_ff;
   logic [7:0]               s1_green_ff;
   logic [MODE_W-1:0]        s1_mode_ff;
   logic                     s1_valid_in, s1_valid_ff;

   // Stage 2 signals
   logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
   logic [7:0]              s2_r_in, s2_r_ff;
   logic [7:0]              s2_g_in, s2_g_ff;
   logic [7:0]              s2_b_in, s2_b_ff;
   logic [7:0]              s2_green_ff;
   logic [MODE_W-1:0]       s2_mode_ff;
   logic                    s2_valid_ff;

   // Stage 3 signals
   logic [SUM_W-1:0]       rgb_sum;
   logic [GREY_PROD_W-1:0] grey_prod;
   logic [7:0]             grey;
   rsp_type                rsp_in, rsp_ff;
   logic                   rsp_strobe_ff;

   // Handshakes: only reset holds off either channel
   assign busy      = reset;
   assign csr_ready = !reset;

   // Write the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   // Stage 1: remove offsets and multiply by the coefficients
   assign s1_valid_in = start && !busy;
   assign luma_off    = $signed({1'b0, req_data.luma_sample}) - LUMA_OFFSET;
   assign cb_off      = $signed({~req_data.blue_diff_sample[7],
                                 req_data.blue_diff_sample[6:0]});
   assign cr_off      = $signed({~req_data.red_diff_sample[7],
                                 req_data.red_diff_sample[6:0]});

   always_comb begin
      s1_y_in  = PROD_W'(luma_off) * COEF_Y;
      s1_rv_in = PROD_W'(cr_off) * COEF_RV;
      s1_gu_in = PROD_W'(cb_off) * COEF_GU;
      s1_gv_in = PROD_W'(cr_off) * COEF_GV;
      s1_bu_in = PROD_W'(cb_off) * COEF_BU;
   end

   always_ff @(posedge clock) begin
      s1_y_ff     <= s1_y_in;
      s1_rv_ff    <= s1_rv_in;
      s1_gu_ff    <= s1_gu_in;
      s1_gv_ff    <= s1_gv_in;
      s1_bu_ff    <= s1_bu_in;
      s1_green_ff <= luma_off[7:0];
      s1_mode_ff  <= mode_ff;
   end

   // Stage 2: sum products, floor shift and clamp each channel
   always_comb begin
      acc_r   = ACC_W'(s1_y_ff) + ACC_W'(s1_rv_ff);
      acc_g   = ACC_W'(s1_y_ff) - ACC_W'(s1_gu_ff) - ACC_W'(s1_gv_ff);
      acc_b   = ACC_W'(s1_y_ff) + ACC_W'(s1_bu_ff);
      s2_r_in = clamp_pixel(acc_r);
      s2_g_in = clamp_pixel(acc_g);
      s2_b_in = clamp_pixel(acc_b);
   end

   always_ff @(posedge clock) begin
      s2_r_ff     <= s2_r_in;
      s2_g_ff     <= s2_g_in;
      s2_b_ff     <= s2_b_in;
      s2_green_ff <= s1_green_ff;
      s2_mode_ff  <= s1_mode_ff;
   end

   // Stage 3: average to grey by reciprocal multiply, then select by mode
   always_comb begin
      rgb_sum   = SUM_W'(s2_r_ff) + SUM_W'(s2_g_ff) + SUM_W'(s2_b_ff);
      grey_prod = GREY_PROD_W'(rgb_sum) * GREY_RECIP;
      grey      = grey_prod[GREY_SHIFT +: 8];
      case (s2_mode_ff)
         MODE_GREY: begin
            rsp_in.red_out   = grey;
            rsp_in.green_out = grey;
            rsp_in.blue_out  = grey;
         end
         MODE_COLOUR: begin
            rsp_in.red_out   = s2_r_ff;
            rsp_in.green_out = s2_g_ff;
            rsp_in.blue_out  = s2_b_ff;
         end
         MODE_GREEN: begin
            rsp_in.red_out   = 8'd0;
            rsp_in.green_out = s2_green_ff;
            rsp_in.blue_out  = 8'd0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         rsp_strobe_ff <= s2_valid_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   `YRM_ASSERT_NEXT(a_latency, clock, reset, start && !busy, ##2 rsp_strobe)
   `YRM_ASSERT_SAME(a_green_zero, clock, reset, rsp_strobe && ($past(s2_mode_ff) == MODE_GREEN), (rsp_data.red_out == 8'd0) && (rsp_data.blue_out == 8'd0))
   `YRM_ASSERT_SAME(a_grey_equal, clock, reset, rsp_strobe && ($past(s2_mode_ff) == MODE_GREY), (rsp_data.red_out == rsp_data.green_out) && (rsp_data.green_out == rsp_data.blue_out))

endmodule

`default_nettype wire
